### rtl/tgr_pkg.sv
`timescale 1ns / 1ps

package tgr_pkg;

  localparam int COUNT_W    = 3;
  localparam int RAW_W      = 12;
  localparam int TIME_W     = 32;
  localparam int COORD_W    = 9;
  localparam int DELTA_W    = COORD_W + 1;
  localparam int DIST_W     = 9;
  localparam int MS_W       = 16;
  localparam int GEST_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int SCREEN_WIDTH_DEF  = 240;
  localparam int SCREEN_HEIGHT_DEF = 320;

  localparam logic [DIST_W-1:0] SWIPE_DISTANCE_RST  = DIST_W'(40);
  localparam logic [MS_W-1:0]   LONG_PRESS_TIME_RST = MS_W'(600);
  localparam logic [MS_W-1:0]   TAP_PAIR_GAP_RST    = MS_W'(300);
  localparam logic [MS_W-1:0]   MIN_TAP_TIME_RST    = MS_W'(25);
  localparam logic [DIST_W-1:0] JITTER_DISTANCE_RST = DIST_W'(6);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SWAP_AXES       = 3'd0,
    CFG_MIRROR_X        = 3'd1,
    CFG_MIRROR_Y        = 3'd2,
    CFG_SWIPE_DISTANCE  = 3'd3,
    CFG_LONG_PRESS_TIME = 3'd4,
    CFG_TAP_PAIR_GAP    = 3'd5,
    CFG_MIN_TAP_TIME    = 3'd6,
    CFG_JITTER_DISTANCE = 3'd7
  } cfg_idx_t;

  typedef enum logic [GEST_W-1:0] {
    GEST_NONE   = 3'd0,
    GEST_TAP    = 3'd1,
    GEST_DOUBLE = 3'd2,
    GEST_LONG   = 3'd3,
    GEST_LEFT   = 3'd4,
    GEST_RIGHT  = 3'd5,
    GEST_UP     = 3'd6,
    GEST_DOWN   = 3'd7
  } gesture_t;

  typedef struct packed {
    logic              swap_axes;
    logic              mirror_x;
    logic              mirror_y;
    logic [DIST_W-1:0] swipe_distance;
    logic [MS_W-1:0]   long_press_time;
    logic [MS_W-1:0]   tap_pair_gap;
    logic [MS_W-1:0]   min_tap_time;
    logic [DIST_W-1:0] jitter_distance;
  } cfg_t;

  typedef struct packed {
    logic               down;
    logic [TIME_W-1:0]  time_ms;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } sample_t;

  typedef struct packed {
    gesture_t           gesture;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
  } result_t;

endpackage

### rtl/tgr_if.sv
`timescale 1ns / 1ps

interface tgr_in_if;
  logic                         valid;
  logic                         ready;
  logic [tgr_pkg::COUNT_W-1:0]  touch_count;
  logic [tgr_pkg::RAW_W-1:0]    raw_x;
  logic [tgr_pkg::RAW_W-1:0]    raw_y;
  logic [tgr_pkg::TIME_W-1:0]   time_ms;

  modport source (output valid, touch_count, raw_x, raw_y, time_ms, input ready);
  modport sink   (input valid, touch_count, raw_x, raw_y, time_ms, output ready);
endinterface

interface tgr_out_if;
  logic                         valid;
  logic                         ready;
  logic [tgr_pkg::GEST_W-1:0]   gesture;
  logic [tgr_pkg::COORD_W-1:0]  pos_x;
  logic [tgr_pkg::COORD_W-1:0]  pos_y;

  modport source (output valid, gesture, pos_x, pos_y, input ready);
  modport sink   (input valid, gesture, pos_x, pos_y, output ready);
endinterface

### rtl/tgr_cfg.sv
`timescale 1ns / 1ps

module tgr_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [tgr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tgr_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output tgr_pkg::cfg_t                     cfg
);

  tgr_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.swap_axes       <= 1'b0;
      cfg_r.mirror_x        <= 1'b0;
      cfg_r.mirror_y        <= 1'b0;
      cfg_r.swipe_distance  <= tgr_pkg::SWIPE_DISTANCE_RST;
      cfg_r.long_press_time <= tgr_pkg::LONG_PRESS_TIME_RST;
      cfg_r.tap_pair_gap    <= tgr_pkg::TAP_PAIR_GAP_RST;
      cfg_r.min_tap_time    <= tgr_pkg::MIN_TAP_TIME_RST;
      cfg_r.jitter_distance <= tgr_pkg::JITTER_DISTANCE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        tgr_pkg::CFG_SWAP_AXES:         cfg_r.swap_axes <= cfg_wdata[0];
        tgr_pkg::CFG_MIRROR_X:          cfg_r.mirror_x <= cfg_wdata[0];
        tgr_pkg::CFG_MIRROR_Y:          cfg_r.mirror_y <= cfg_wdata[0];
        tgr_pkg::CFG_SWIPE_DISTANCE:
          cfg_r.swipe_distance <= cfg_wdata[tgr_pkg::DIST_W-1:0];
        tgr_pkg::CFG_LONG_PRESS_TIME:
          cfg_r.long_press_time <= cfg_wdata[tgr_pkg::MS_W-1:0];
        tgr_pkg::CFG_TAP_PAIR_GAP:
          cfg_r.tap_pair_gap <= cfg_wdata[tgr_pkg::MS_W-1:0];
        tgr_pkg::CFG_MIN_TAP_TIME:
          cfg_r.min_tap_time <= cfg_wdata[tgr_pkg::MS_W-1:0];
        tgr_pkg::CFG_JITTER_DISTANCE:
          cfg_r.jitter_distance <= cfg_wdata[tgr_pkg::DIST_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/tgr_map.sv
`timescale 1ns / 1ps

module tgr_map #(
  parameter int SCREEN_WIDTH  = tgr_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = tgr_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic [tgr_pkg::COUNT_W-1:0] touch_count,
  input  logic [tgr_pkg::RAW_W-1:0]   raw_x,
  input  logic [tgr_pkg::RAW_W-1:0]   raw_y,
  input  logic [tgr_pkg::TIME_W-1:0]  time_ms,
  input  tgr_pkg::cfg_t               cfg,
  output tgr_pkg::sample_t            sample
);

  localparam int CW     = tgr_pkg::COORD_W;
  localparam int PROD_W = tgr_pkg::RAW_W + CW;
  localparam logic [CW-1:0] W_PX  = CW'(SCREEN_WIDTH);
  localparam logic [CW-1:0] H_PX  = CW'(SCREEN_HEIGHT);
  localparam logic [CW-1:0] W_MAX = CW'(SCREEN_WIDTH - 1);
  localparam logic [CW-1:0] H_MAX = CW'(SCREEN_HEIGHT - 1);

  logic [PROD_W-1:0] prod_x, prod_y;
  logic [CW-1:0]     sx, sy, cx, cy, wx, wy;

  always_comb begin
    prod_x = PROD_W'(raw_x) * PROD_W'(W_PX);
    prod_y = PROD_W'(raw_y) * PROD_W'(H_PX);
    sx = prod_x[PROD_W-1:tgr_pkg::RAW_W];
    sy = prod_y[PROD_W-1:tgr_pkg::RAW_W];
    if (sx >= W_PX) sx = W_MAX;
    if (sy >= H_PX) sy = H_MAX;
    cx = cfg.swap_axes ? sy : sx;
    cy = cfg.swap_axes ? sx : sy;
    wx = cx;
    wy = cy;
    if (cfg.mirror_x) wx = (cx <= W_MAX) ? W_MAX - cx : '0;
    if (cfg.mirror_y) wy = (cy <= H_MAX) ? H_MAX - cy : '0;
    sample.down    = (touch_count != '0);
    sample.time_ms = time_ms;
    sample.x       = wx;
    sample.y       = wy;
  end

endmodule

### rtl/tgr_track.sv
`timescale 1ns / 1ps

module tgr_track (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  tgr_pkg::sample_t  sample,
  input  tgr_pkg::cfg_t     cfg,
  output tgr_pkg::result_t  result
);

  localparam int CW = tgr_pkg::COORD_W;
  localparam int DW = tgr_pkg::DELTA_W;
  localparam int TW = tgr_pkg::TIME_W;

  logic          pressed_r, pressed_nxt;
  logic          long_done_r, long_done_nxt;
  logic [TW-1:0] press_time_r, press_time_nxt;
  logic [TW-1:0] last_tap_r, last_tap_nxt;
  logic [CW-1:0] origin_x_r, origin_x_nxt, origin_y_r, origin_y_nxt;
  logic [CW-1:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [CW-1:0] peak_dx_r, peak_dx_nxt, peak_dy_r, peak_dy_nxt;
  logic [DW-1:0] last_dx_r, last_dx_nxt, last_dy_r, last_dy_nxt;

  logic [DW-1:0] dx, dy, ndx, ndy, nlx, nly;
  logic [CW-1:0] adx, ady, alx, aly;
  logic [TW-1:0] held, gap;
  logic          move;

  always_comb begin
    dx   = {1'b0, sample.x} - {1'b0, origin_x_r};
    dy   = {1'b0, sample.y} - {1'b0, origin_y_r};
    ndx  = -dx;
    ndy  = -dy;
    adx  = dx[DW-1] ? ndx[CW-1:0] : dx[CW-1:0];
    ady  = dy[DW-1] ? ndy[CW-1:0] : dy[CW-1:0];
    nlx  = -last_dx_r;
    nly  = -last_dy_r;
    alx  = last_dx_r[DW-1] ? nlx[CW-1:0] : last_dx_r[CW-1:0];
    aly  = last_dy_r[DW-1] ? nly[CW-1:0] : last_dy_r[CW-1:0];
    held = sample.time_ms - press_time_r;
    gap  = sample.time_ms - last_tap_r;
    move = (adx > cfg.jitter_distance) || (ady > cfg.jitter_distance);

    pressed_nxt    = pressed_r;
    long_done_nxt  = long_done_r;
    press_time_nxt = press_time_r;
    last_tap_nxt   = last_tap_r;
    origin_x_nxt   = origin_x_r;
    origin_y_nxt   = origin_y_r;
    cur_x_nxt      = cur_x_r;
    cur_y_nxt      = cur_y_r;
    peak_dx_nxt    = peak_dx_r;
    peak_dy_nxt    = peak_dy_r;
    last_dx_nxt    = last_dx_r;
    last_dy_nxt    = last_dy_r;
    result.gesture = tgr_pkg::GEST_NONE;
    result.pos_x   = '0;
    result.pos_y   = '0;

    if (sample.down && !pressed_r) begin
      pressed_nxt    = 1'b1;
      press_time_nxt = sample.time_ms;
      origin_x_nxt   = sample.x;
      origin_y_nxt   = sample.y;
      cur_x_nxt      = sample.x;
      cur_y_nxt      = sample.y;
      peak_dx_nxt    = '0;
      peak_dy_nxt    = '0;
      last_dx_nxt    = '0;
      last_dy_nxt    = '0;
      long_done_nxt  = 1'b0;
    end else if (sample.down) begin
      if (move) begin
        cur_x_nxt   = sample.x;
        cur_y_nxt   = sample.y;
        last_dx_nxt = dx;
        last_dy_nxt = dy;
        if (adx > peak_dx_r) peak_dx_nxt = adx;
        if (ady > peak_dy_r) peak_dy_nxt = ady;
      end
      if (!long_done_r && (held >= TW'(cfg.long_press_time)) &&
          (peak_dx_nxt < cfg.swipe_distance) && (peak_dy_nxt < cfg.swipe_distance)) begin
        long_done_nxt  = 1'b1;
        result.gesture = tgr_pkg::GEST_LONG;
        result.pos_x   = cur_x_nxt;
        result.pos_y   = cur_y_nxt;
      end
    end else if (pressed_r) begin
      pressed_nxt = 1'b0;
      if (!long_done_r && (held >= TW'(cfg.min_tap_time))) begin
        if ((alx >= cfg.swipe_distance) || (aly >= cfg.swipe_distance)) begin
          if (alx > aly) begin
            result.gesture = (!last_dx_r[DW-1] && (last_dx_r != '0)) ?
                             tgr_pkg::GEST_RIGHT : tgr_pkg::GEST_LEFT;
          end else begin
            result.gesture = (!last_dy_r[DW-1] && (last_dy_r != '0)) ?
                             tgr_pkg::GEST_DOWN : tgr_pkg::GEST_UP;
          end
        end else if ((last_tap_r != '0) && (gap <= TW'(cfg.tap_pair_gap))) begin
          last_tap_nxt   = '0;
          result.gesture = tgr_pkg::GEST_DOUBLE;
        end else begin
          last_tap_nxt   = sample.time_ms;
          result.gesture = tgr_pkg::GEST_TAP;
        end
        result.pos_x = cur_x_r;
        result.pos_y = cur_y_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressed_r    <= 1'b0;
      long_done_r  <= 1'b0;
      press_time_r <= '0;
      last_tap_r   <= '0;
      origin_x_r   <= '0;
      origin_y_r   <= '0;
      cur_x_r      <= '0;
      cur_y_r      <= '0;
      peak_dx_r    <= '0;
      peak_dy_r    <= '0;
      last_dx_r    <= '0;
      last_dy_r    <= '0;
    end else if (en) begin
      pressed_r    <= pressed_nxt;
      long_done_r  <= long_done_nxt;
      press_time_r <= press_time_nxt;
      last_tap_r   <= last_tap_nxt;
      origin_x_r   <= origin_x_nxt;
      origin_y_r   <= origin_y_nxt;
      cur_x_r      <= cur_x_nxt;
      cur_y_r      <= cur_y_nxt;
      peak_dx_r    <= peak_dx_nxt;
      peak_dy_r    <= peak_dy_nxt;
      last_dx_r    <= last_dx_nxt;
      last_dy_r    <= last_dy_nxt;
    end
  end

endmodule

### rtl/touch_gesture_recognizer_core.sv
`timescale 1ns / 1ps

// Port     Dir  Kind                Payload
// in_ch    in   valid/ready sink    touch_count, raw_x, raw_y, time_ms
// out_ch   out  valid/ready source  gesture, pos_x, pos_y
// cfg_*    in   write only          cfg_we, cfg_index, cfg_wdata
//
// One sample per cycle sustained while out_ch.ready is high; a result is valid once
// its input has passed the scaled-sample register, then the result register, so its
// own transfer follows both register loads at the earliest.
// Gesture state advances when a sample moves into the result register.
// Synchronous active-low reset restores register defaults and clears state.
// A stalled output holds both stages; in_ch.ready drops only when both are full.

module touch_gesture_recognizer_core #(
  parameter int SCREEN_WIDTH  = tgr_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = tgr_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  tgr_in_if.sink                          in_ch,
  tgr_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [tgr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tgr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  tgr_pkg::cfg_t    cfg;
  tgr_pkg::sample_t sample, s1_r;
  tgr_pkg::result_t res, out_r;
  logic             s1_valid_r, out_valid_r;
  logic             out_free, adv, in_xfer;

  tgr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tgr_map #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_map (
    .touch_count (in_ch.touch_count),
    .raw_x       (in_ch.raw_x),
    .raw_y       (in_ch.raw_y),
    .time_ms     (in_ch.time_ms),
    .cfg         (cfg),
    .sample      (sample)
  );

  tgr_track u_track (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .sample (s1_r),
    .cfg    (cfg),
    .result (res)
  );

  assign out_free    = !out_valid_r || out_ch.ready;
  assign adv         = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) s1_valid_r <= in_ch.valid;
      if (out_free) out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) s1_r <= sample;
    if (adv) out_r <= res;
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.gesture = out_r.gesture;
  assign out_ch.pos_x   = out_r.pos_x;
  assign out_ch.pos_y   = out_r.pos_y;

endmodule

### dv/touch_gesture_recognizer_core_tb.sv
`timescale 1ns / 1ps

module touch_gesture_recognizer_core_tb;

  localparam int SCR_W           = tgr_pkg::SCREEN_WIDTH_DEF;
  localparam int SCR_H           = tgr_pkg::SCREEN_HEIGHT_DEF;
  localparam int WATCHDOG_CYCLES = 4000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int MAX_REPORTED    = 40;

  typedef struct packed {
    logic [tgr_pkg::COUNT_W-1:0] count;
    logic [tgr_pkg::RAW_W-1:0]   raw_x;
    logic [tgr_pkg::RAW_W-1:0]   raw_y;
    logic [tgr_pkg::TIME_W-1:0]  time_ms;
  } touch_sample_t;

  typedef struct packed {
    logic                        held;
    logic [tgr_pkg::TIME_W-1:0]  press_ms;
    logic [tgr_pkg::COORD_W-1:0] org_x;
    logic [tgr_pkg::COORD_W-1:0] org_y;
    logic [tgr_pkg::COORD_W-1:0] cur_x;
    logic [tgr_pkg::COORD_W-1:0] cur_y;
    logic [tgr_pkg::COORD_W-1:0] peak_x;
    logic [tgr_pkg::COORD_W-1:0] peak_y;
    logic [tgr_pkg::DELTA_W-1:0] move_x;
    logic [tgr_pkg::DELTA_W-1:0] move_y;
    logic                        long_fired;
    logic [tgr_pkg::TIME_W-1:0]  tap_ms;
  } touch_track_t;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           cfg_we;
  logic [tgr_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [tgr_pkg::CFG_DATA_W-1:0] cfg_wdata;

  tgr_in_if  in_ch ();
  tgr_out_if out_ch ();

  touch_gesture_recognizer_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tgr_pkg::cfg_t    shadow_cfg;
  touch_track_t     trk;
  tgr_pkg::result_t pending_gestures[$];
  tgr_pkg::result_t next_want;
  logic [31:0]      stroke_ms;
  int               send_idle_pct;
  int               recv_stall_pct;
  int               pause_every;
  int               samples_sent;
  int               reports_checked;
  int               configs_loaded;
  int               mismatches;
  int               quiet_cycles;
  int               seen_by_gesture[8];

  function automatic tgr_pkg::cfg_t default_cfg();
    tgr_pkg::cfg_t c;
    c.swap_axes       = 1'b0;
    c.mirror_x        = 1'b0;
    c.mirror_y        = 1'b0;
    c.swipe_distance  = tgr_pkg::SWIPE_DISTANCE_RST;
    c.long_press_time = tgr_pkg::LONG_PRESS_TIME_RST;
    c.tap_pair_gap    = tgr_pkg::TAP_PAIR_GAP_RST;
    c.min_tap_time    = tgr_pkg::MIN_TAP_TIME_RST;
    c.jitter_distance = tgr_pkg::JITTER_DISTANCE_RST;
    return c;
  endfunction

  function automatic tgr_pkg::cfg_t random_cfg();
    tgr_pkg::cfg_t c;
    c.swap_axes       = 1'($urandom_range(0, 1));
    c.mirror_x        = 1'($urandom_range(0, 1));
    c.mirror_y        = 1'($urandom_range(0, 1));
    c.swipe_distance  = tgr_pkg::DIST_W'($urandom_range(10, 90));
    c.long_press_time = tgr_pkg::MS_W'($urandom_range(50, 1500));
    c.tap_pair_gap    = tgr_pkg::MS_W'($urandom_range(50, 800));
    c.min_tap_time    = tgr_pkg::MS_W'($urandom_range(0, 80));
    c.jitter_distance = tgr_pkg::DIST_W'($urandom_range(0, 15));
    return c;
  endfunction

  function automatic touch_sample_t touch(int pts, int rx, int ry, logic [31:0] ms);
    touch_sample_t s;
    s.count   = tgr_pkg::COUNT_W'(pts);
    s.raw_x   = tgr_pkg::RAW_W'(rx);
    s.raw_y   = tgr_pkg::RAW_W'(ry);
    s.time_ms = ms;
    return s;
  endfunction

  function automatic int scale_px(logic [tgr_pkg::RAW_W-1:0] raw, int size);
    int v;
    v = int'(raw) * size / 4096;
    if (v >= size) v = size - 1;
    return v;
  endfunction

  function automatic int magnitude(int d);
    return (d < 0) ? -d : d;
  endfunction

  // Advances the tracked touch by one sample and returns the gesture it yields.
  function automatic tgr_pkg::result_t recognize_gesture(touch_sample_t s);
    int               x, y, tmp, dx, dy, adx, ady;
    logic [31:0]      held_ms, since_tap;
    tgr_pkg::result_t r;
    r.gesture = tgr_pkg::GEST_NONE;
    r.pos_x   = '0;
    r.pos_y   = '0;
    x = scale_px(s.raw_x, SCR_W);
    y = scale_px(s.raw_y, SCR_H);
    if (shadow_cfg.swap_axes) begin
      tmp = x;
      x   = y;
      y   = tmp;
    end
    if (shadow_cfg.mirror_x) x = (x <= SCR_W - 1) ? SCR_W - 1 - x : 0;
    if (shadow_cfg.mirror_y) y = (y <= SCR_H - 1) ? SCR_H - 1 - y : 0;
    held_ms = s.time_ms - trk.press_ms;

    if (s.count != 0 && !trk.held) begin
      trk.held       = 1'b1;
      trk.press_ms   = s.time_ms;
      trk.org_x      = tgr_pkg::COORD_W'(x);
      trk.org_y      = tgr_pkg::COORD_W'(y);
      trk.cur_x      = tgr_pkg::COORD_W'(x);
      trk.cur_y      = tgr_pkg::COORD_W'(y);
      trk.peak_x     = '0;
      trk.peak_y     = '0;
      trk.move_x     = '0;
      trk.move_y     = '0;
      trk.long_fired = 1'b0;
    end else if (s.count != 0) begin
      dx  = x - int'(trk.org_x);
      dy  = y - int'(trk.org_y);
      adx = magnitude(dx);
      ady = magnitude(dy);
      if (adx > shadow_cfg.jitter_distance || ady > shadow_cfg.jitter_distance) begin
        trk.cur_x = tgr_pkg::COORD_W'(x);
        trk.cur_y = tgr_pkg::COORD_W'(y);
        if (adx > trk.peak_x) trk.peak_x = tgr_pkg::COORD_W'(adx);
        if (ady > trk.peak_y) trk.peak_y = tgr_pkg::COORD_W'(ady);
        trk.move_x = tgr_pkg::DELTA_W'(dx);
        trk.move_y = tgr_pkg::DELTA_W'(dy);
      end
      if (!trk.long_fired && held_ms >= shadow_cfg.long_press_time &&
          trk.peak_x < shadow_cfg.swipe_distance &&
          trk.peak_y < shadow_cfg.swipe_distance) begin
        trk.long_fired = 1'b1;
        r.gesture = tgr_pkg::GEST_LONG;
        r.pos_x   = trk.cur_x;
        r.pos_y   = trk.cur_y;
      end
    end else if (trk.held) begin
      trk.held = 1'b0;
      if (!trk.long_fired && held_ms >= shadow_cfg.min_tap_time) begin
        dx        = int'($signed(trk.move_x));
        dy        = int'($signed(trk.move_y));
        adx       = magnitude(dx);
        ady       = magnitude(dy);
        since_tap = s.time_ms - trk.tap_ms;
        if (adx >= shadow_cfg.swipe_distance || ady >= shadow_cfg.swipe_distance) begin
          if (adx > ady) r.gesture = (dx > 0) ? tgr_pkg::GEST_RIGHT : tgr_pkg::GEST_LEFT;
          else r.gesture = (dy > 0) ? tgr_pkg::GEST_DOWN : tgr_pkg::GEST_UP;
        end else if (trk.tap_ms != 0 && since_tap <= shadow_cfg.tap_pair_gap) begin
          trk.tap_ms = '0;
          r.gesture  = tgr_pkg::GEST_DOUBLE;
        end else begin
          trk.tap_ms = s.time_ms;
          r.gesture  = tgr_pkg::GEST_TAP;
        end
        r.pos_x = trk.cur_x;
        r.pos_y = trk.cur_y;
      end
    end
    return r;
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    if (mismatches < MAX_REPORTED)
      $display("%0t mismatch: %s got %0d want %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic send_sample(touch_sample_t s);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.touch_count <= s.count;
    in_ch.raw_x       <= s.raw_x;
    in_ch.raw_y       <= s.raw_y;
    in_ch.time_ms     <= s.time_ms;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_gestures.push_back(recognize_gesture(s));
    samples_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending_gestures.size() != 0);
  endtask

  task automatic put_reg(tgr_pkg::cfg_idx_t idx, int unsigned value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= tgr_pkg::CFG_DATA_W'(value);
    @(negedge clk);
  endtask

  task automatic load_config(tgr_pkg::cfg_t c);
    wait_drained();
    put_reg(tgr_pkg::CFG_SWAP_AXES, c.swap_axes);
    put_reg(tgr_pkg::CFG_MIRROR_X, c.mirror_x);
    put_reg(tgr_pkg::CFG_MIRROR_Y, c.mirror_y);
    put_reg(tgr_pkg::CFG_SWIPE_DISTANCE, c.swipe_distance);
    put_reg(tgr_pkg::CFG_LONG_PRESS_TIME, c.long_press_time);
    put_reg(tgr_pkg::CFG_TAP_PAIR_GAP, c.tap_pair_gap);
    put_reg(tgr_pkg::CFG_MIN_TAP_TIME, c.min_tap_time);
    put_reg(tgr_pkg::CFG_JITTER_DISTANCE, c.jitter_distance);
    cfg_we <= 1'b0;
    shadow_cfg = c;
    configs_loaded++;
  endtask

  task automatic set_idling(int sender_pct, int receiver_pct);
    send_idle_pct  = sender_pct;
    recv_stall_pct = receiver_pct;
  endtask

  function automatic int clamp_raw(int v);
    if (v < 0) return 0;
    if (v > 4095) return 4095;
    return v;
  endfunction

  // One press/move/release sequence with random content, or a noise sample.
  task automatic send_stroke();
    int steps, span, vx, vy, rx, ry;
    if ($urandom_range(0, 9) == 0) begin
      send_sample(touch($urandom_range(0, 7), $urandom_range(0, 4095),
                        $urandom_range(0, 4095), $urandom));
      return;
    end
    stroke_ms += ($urandom_range(0, 3) == 0) ? $urandom_range(0, 80000)
                                              : $urandom_range(0, 400);
    rx = $urandom_range(0, 4095);
    ry = $urandom_range(0, 4095);
    case ($urandom_range(0, 3))
      0: begin
        vx = 0;
        vy = 0;
      end
      1: begin
        vx = int'($urandom_range(0, 1200)) - 600;
        vy = int'($urandom_range(0, 160)) - 80;
      end
      2: begin
        vx = int'($urandom_range(0, 160)) - 80;
        vy = int'($urandom_range(0, 1200)) - 600;
      end
      default: begin
        vx = int'($urandom_range(0, 400)) - 200;
        vy = int'($urandom_range(0, 400)) - 200;
      end
    endcase
    case ($urandom_range(0, 3))
      0: span = 20;
      1: span = 150;
      2: span = 900;
      default: span = 70000;
    endcase
    steps = $urandom_range(0, 6);
    send_sample(touch($urandom_range(1, 7), rx, ry, stroke_ms));
    repeat (steps) begin
      stroke_ms += $urandom_range(0, span);
      rx = clamp_raw(rx + vx + int'($urandom_range(0, 40)) - 20);
      ry = clamp_raw(ry + vy + int'($urandom_range(0, 40)) - 20);
      send_sample(touch($urandom_range(1, 7), rx, ry, stroke_ms));
    end
    // a missing release leaves the next press as a held sample
    if ($urandom_range(0, 9) != 0) begin
      stroke_ms += $urandom_range(0, span);
      send_sample(touch(0, $urandom_range(0, 4095), $urandom_range(0, 4095), stroke_ms));
    end
  endtask

  task automatic run_strokes(int n_items);
    int stop_at, strokes;
    stop_at = samples_sent + n_items;
    strokes = 0;
    while (samples_sent < stop_at) begin
      send_stroke();
      strokes++;
      if (pause_every != 0 && strokes % pause_every == 0) wait_drained();
    end
  endtask

  task automatic test_taps();
    send_sample(touch(0, 4095, 4095, 5));
    // tap released exactly at time zero, across the wrap
    send_sample(touch(7, 4095, 4095, 32'hFFFF_FFE0));
    send_sample(touch(0, 0, 0, 0));
    send_sample(touch(1, 0, 0, 100));
    send_sample(touch(0, 0, 0, 150));
    send_sample(touch(2, 0, 0, 200));
    send_sample(touch(0, 0, 0, 250));
    send_sample(touch(1, 100, 100, 400));
    send_sample(touch(0, 100, 100, 410));
  endtask

  task automatic test_long_press();
    send_sample(touch(1, 2048, 2048, 1000));
    send_sample(touch(1, 2098, 2048, 1300));
    send_sample(touch(1, 2048, 2048, 1600));
    send_sample(touch(0, 2048, 2048, 1800));
  endtask

  task automatic swipe_once(logic [31:0] t0, int rx, int ry);
    send_sample(touch(1, 2048, 2048, t0));
    send_sample(touch(1, rx, ry, t0 + 100));
    send_sample(touch(0, rx, ry, t0 + 200));
  endtask

  task automatic test_swipes();
    swipe_once(3000, 3000, 2048);
    swipe_once(4000, 1000, 2048);
    swipe_once(5000, 2048, 1000);
    swipe_once(6000, 2048, 3000);
  endtask

  task automatic test_axis_mapping();
    tgr_pkg::cfg_t c;
    c = default_cfg();
    c.swap_axes = 1'b1;
    c.mirror_x  = 1'b1;
    c.mirror_y  = 1'b1;
    load_config(c);
    send_sample(touch(1, 4095, 0, 10000));
    send_sample(touch(0, 4095, 0, 10100));
    // swapped Y exceeds the width, so mirrored X saturates at zero
    send_sample(touch(1, 0, 4095, 10500));
    send_sample(touch(0, 0, 4095, 10600));
    c.swipe_distance = '0;
    c.min_tap_time   = '0;
    load_config(c);
    send_sample(touch(1, 1500, 1500, 11000));
    send_sample(touch(0, 1500, 1500, 11000));
  endtask

  task automatic test_threshold_extremes();
    tgr_pkg::cfg_t c;
    c.swap_axes       = 1'b0;
    c.mirror_x        = 1'b1;
    c.mirror_y        = 1'b0;
    c.swipe_distance  = tgr_pkg::DIST_W'(511);
    c.long_press_time = '0;
    c.tap_pair_gap    = '0;
    c.min_tap_time    = '0;
    c.jitter_distance = '0;
    load_config(c);
    set_idling(0, 0);
    run_strokes(250);
    c.swap_axes       = 1'b1;
    c.mirror_x        = 1'b0;
    c.mirror_y        = 1'b1;
    c.swipe_distance  = '0;
    c.long_press_time = tgr_pkg::MS_W'(65535);
    c.tap_pair_gap    = tgr_pkg::MS_W'(65535);
    c.min_tap_time    = tgr_pkg::MS_W'(65535);
    c.jitter_distance = tgr_pkg::DIST_W'(511);
    load_config(c);
    set_idling(82, 0);
    run_strokes(250);
  endtask

  task automatic test_defaults_receiver_stalls();
    load_config(default_cfg());
    set_idling(0, 82);
    run_strokes(250);
  endtask

  task automatic test_streaming();
    load_config(random_cfg());
    set_idling(0, 0);
    run_strokes(250);
  endtask

  task automatic test_sender_gaps();
    load_config(random_cfg());
    set_idling(82, 0);
    run_strokes(250);
  endtask

  task automatic test_mixed_throttle();
    load_config(random_cfg());
    set_idling(31, 31);
    run_strokes(250);
  endtask

  task automatic test_time_wrap();
    load_config(random_cfg());
    set_idling(0, 0);
    stroke_ms = 32'hFFFF_0000 + $urandom_range(0, 32'hF000);
    run_strokes(200);
  endtask

  task automatic test_drain_pauses();
    load_config(random_cfg());
    set_idling(31, 31);
    pause_every = 12;
    run_strokes(200);
    pause_every = 0;
  endtask

  always @(negedge clk) begin
    out_ch.ready <= (recv_stall_pct == 0) || ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_gestures.size() == 0) begin
        flag_mismatch("result with nothing pending, gesture", out_ch.gesture, -1);
      end else begin
        next_want = pending_gestures.pop_front();
        reports_checked++;
        if (out_ch.gesture !== next_want.gesture)
          flag_mismatch("gesture", out_ch.gesture, next_want.gesture);
        if (out_ch.pos_x !== next_want.pos_x)
          flag_mismatch("pos_x", out_ch.pos_x, next_want.pos_x);
        if (out_ch.pos_y !== next_want.pos_y)
          flag_mismatch("pos_y", out_ch.pos_y, next_want.pos_y);
        seen_by_gesture[next_want.gesture]++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_CYCLES) begin
      $display("%0t no transfer for %0d cycles", $time, WATCHDOG_CYCLES);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = tgr_pkg::CFG_SWAP_AXES;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.touch_count = '0;
    in_ch.raw_x       = '0;
    in_ch.raw_y       = '0;
    in_ch.time_ms     = '0;
    out_ch.ready      = 1'b0;
    shadow_cfg        = default_cfg();
    trk               = '0;
    stroke_ms         = 32'd20000;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    pause_every       = 0;
    samples_sent      = 0;
    reports_checked   = 0;
    configs_loaded    = 0;
    mismatches        = 0;
    quiet_cycles      = 0;
    foreach (seen_by_gesture[i]) seen_by_gesture[i] = 0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_taps();
    test_long_press();
    test_swipes();
    test_axis_mapping();
    test_threshold_extremes();
    test_defaults_receiver_stalls();
    test_streaming();
    test_sender_gaps();
    test_mixed_throttle();
    test_time_wrap();
    test_drain_pauses();

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d touch samples, %0d results checked, %0d register setups",
             samples_sent, reports_checked, configs_loaded);
    $display("gestures: tap %0d double %0d long %0d swipe %0d/%0d/%0d/%0d none %0d",
             seen_by_gesture[tgr_pkg::GEST_TAP], seen_by_gesture[tgr_pkg::GEST_DOUBLE],
             seen_by_gesture[tgr_pkg::GEST_LONG], seen_by_gesture[tgr_pkg::GEST_LEFT],
             seen_by_gesture[tgr_pkg::GEST_RIGHT], seen_by_gesture[tgr_pkg::GEST_UP],
             seen_by_gesture[tgr_pkg::GEST_DOWN], seen_by_gesture[tgr_pkg::GEST_NONE]);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### touch_gesture_recognizer_core.f
rtl/tgr_pkg.sv
rtl/tgr_if.sv
rtl/tgr_cfg.sv
rtl/tgr_map.sv
rtl/tgr_track.sv
rtl/touch_gesture_recognizer_core.sv
dv/touch_gesture_recognizer_core_tb.sv
